[sv/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg
// shared constants and codes for the sorted list insert/delete unit
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

[sv/sorted_list_insert_delete_unit.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// bounded ascending store of signed 32-bit values with insert and delete
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------------
//  request   | req_type, value                         | start high, busy low
//  result    | status, count_after, head_valid,        | done high for one cycle,
//            | head_value                              | no back pressure
//
//  one item in flight at a time; busy stays high through its result strobe
//  time per item grows with the walk: an insert moves down from the top,
//  shifting larger or equal values up to make room; a delete scans up from
//  slot 0 and moves later values down over a match; a full-store insert
//  skips the walk; the store (one read and one write a cycle, read data
//  registered) and the compare/shift sequencer set the pace
//  reset clears the count and the sequencer; store contents are not cleared
//  the receiver cannot stall: done pulses once and the result is taken then
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   req_type,
    input  logic signed [sli_pkg::DATA_W-1:0]      value,
    output logic                                   done,
    output logic        [sli_pkg::STATUS_W-1:0]    status,
    output logic        [sli_pkg::COUNT_OUT_W-1:0] count_after,
    output logic                                   head_valid,
    output logic signed [sli_pkg::DATA_W-1:0]      head_value
);
    import sli_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INS_RD = 8'b0000_0010,
        S_INS_CM = 8'b0000_0100,
        S_DEL_RD = 8'b0000_1000,
        S_DEL_CM = 8'b0001_0000,
        S_HD_RD  = 8'b0010_0000,
        S_HD_WT  = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // store: one write and one read each cycle, read data registered
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic        [ADDR_W-1:0] rd_addr;
    logic                     wr_en;
    logic        [ADDR_W-1:0] wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    // control and working registers
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic                     found_reg, found_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    status_t                  st_reg, st_next;

    // result registers
    logic                     done_reg, done_next;
    status_t                  status_reg, status_next;
    logic [COUNT_OUT_W-1:0]   count_out_reg, count_out_next;
    logic                     head_valid_reg, head_valid_next;
    logic signed [DATA_W-1:0] head_value_reg, head_value_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        val_next        = val_reg;
        st_next         = st_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        count_out_next  = count_out_reg;
        head_valid_next = head_valid_reg;
        head_value_next = head_value_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[ADDR_W-1:0];
        wr_data         = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next   = value;
                    found_next = 1'b0;
                    if (req_type == REQ_INSERT)
                    begin
                        if (count_reg >= CAP_CNT)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_HD_RD;
                        end
                        else
                        begin
                            // walk down from the top slot, shifting larger or equal values up
                            ptr_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        ptr_next   = '0;
                        state_next = S_DEL_RD;
                    end
                end
            end

            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    // reached the bottom: new value becomes the head
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = count_reg + 1'b1;
                    st_next    = ST_INSERTED;
                    state_next = S_HD_RD;
                end
                else
                begin
                    rd_addr    = ADDR_W'(ptr_reg - 1'b1);
                    state_next = S_INS_CM;
                end
            end

            S_INS_CM:
            begin
                wr_en = 1'b1;
                if (rd_data_reg < val_reg)
                begin
                    // slot below holds a smaller value: place here
                    count_next = count_reg + 1'b1;
                    st_next    = ST_INSERTED;
                    state_next = S_HD_RD;
                end
                else
                begin
                    wr_data    = rd_data_reg;
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = S_INS_RD;
                end
            end

            S_DEL_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        st_next    = ST_DELETED;
                    end
                    else
                    begin
                        st_next = ST_NOT_FOUND;
                    end
                    state_next = S_HD_RD;
                end
                else
                begin
                    rd_addr    = ptr_reg[ADDR_W-1:0];
                    state_next = S_DEL_CM;
                end
            end

            S_DEL_CM:
            begin
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_DEL_RD;
                if (found_reg)
                begin
                    // close the gap: move this value down one slot
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(ptr_reg - 1'b1);
                    wr_data = rd_data_reg;
                end
                else if (rd_data_reg == val_reg)
                begin
                    found_next = 1'b1;
                end
                else if (rd_data_reg > val_reg)
                begin
                    // sorted order: no equal value further up
                    st_next    = ST_NOT_FOUND;
                    state_next = S_HD_RD;
                end
            end

            S_HD_RD:
            begin
                rd_addr    = '0;
                state_next = S_HD_WT;
            end

            S_HD_WT:
            begin
                done_next       = 1'b1;
                status_next     = st_reg;
                count_out_next  = COUNT_OUT_W'(count_reg);
                head_valid_next = (count_reg != '0);
                head_value_next = (count_reg != '0) ? rd_data_reg : '0;
                state_next      = S_FIN;
            end

            S_FIN:
            begin
                // result strobe goes out this cycle
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        found_reg      <= found_next;
        val_reg        <= val_next;
        st_reg         <= st_next;
        status_reg     <= status_next;
        count_out_reg  <= count_out_next;
        head_valid_reg <= head_valid_next;
        head_value_reg <= head_value_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign count_after = count_out_reg;
    assign head_valid  = head_valid_reg;
    assign head_value  = head_value_reg;

endmodule
